// ===== hw/rtl/dtq_pkg.sv =====
// ============================================================================
// dtq_pkg: shared types and constants for the deadline timer queue
// Holds sizes, command and status codes, and the cell-to-cell record.
// ============================================================================
package dtq_pkg;

   localparam int Capacity   = 16;
   localparam int HandleBits = 16;
   localparam int SlotBits   = (Capacity > 1) ? $clog2(Capacity) : 1;
   localparam int TimeBits   = 48;
   localparam int RemainBits = 31;
   localparam int MaxResults = 16;

   localparam logic [TimeBits-1:0]   TimeMax   = {TimeBits{1'b1}};
   localparam logic [RemainBits-1:0] RemainMax = {RemainBits{1'b1}};

   typedef enum logic [1:0] {
      CMD_ADD    = 2'd0,
      CMD_CANCEL = 2'd1,
      CMD_QUERY  = 2'd2,
      CMD_EXPIRE = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2,
      ST_BADID = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE = 2'd0,
      S_SCAN = 2'd1,
      S_EMIT = 2'd2
   } state_type;

   // Running best candidate handed from cell to cell during a scan
   typedef struct packed {
      logic                found;
      logic [SlotBits-1:0] slot;
      logic [TimeBits-1:0] deadline;
   } best_type;

   // Per-cell control from the sequencer
   typedef struct packed {
      logic                write;
      logic                clear;
      logic [SlotBits-1:0] slot;
   } cell_ctl_type;

endpackage

// ===== hw/rtl/dtq_cell.sv =====
// ============================================================================
// dtq_cell: one timer slot
// Stores one deadline, handle and notify flag with a live bit, and folds its
// own entry into the running minimum that passes through the row.
// ============================================================================
module dtq_cell (
   input  logic                            clock,
   input  logic                            reset,
   input  logic [dtq_pkg::SlotBits-1:0]    my_slot,
   input  dtq_pkg::cell_ctl_type           ctl,
   input  logic [dtq_pkg::TimeBits-1:0]    wr_deadline,
   input  logic [dtq_pkg::HandleBits-1:0]  wr_handle,
   input  logic                            wr_notify,
   input  dtq_pkg::best_type               best_i,
   output dtq_pkg::best_type               best_o,
   output logic                            live,
   output logic [dtq_pkg::TimeBits-1:0]    deadline,
   output logic [dtq_pkg::HandleBits-1:0]  handle,
   output logic                            notify_flag
);
   import dtq_pkg::*;

   logic                  live_ff, live_in;
   logic [TimeBits-1:0]   deadline_ff;
   logic [HandleBits-1:0] handle_ff;
   logic                  notify_ff;
   logic                  hit;

   assign hit = (ctl.slot == my_slot);

   // Set on write, drop on clear
   always_comb begin
      live_in = live_ff;
      if (ctl.write && hit) live_in = 1'b1;
      else if (ctl.clear && hit) live_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         live_ff <= 1'b0;
      end else begin
         live_ff <= live_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.write && hit) begin
         deadline_ff <= wr_deadline;
         handle_ff   <= wr_handle;
         notify_ff   <= wr_notify;
      end
   end

   // Strict less keeps the lower slot on ties since slots pass in order
   always_comb begin
      best_o = best_i;
      if (live_ff && (!best_i.found || deadline_ff < best_i.deadline)) begin
         best_o.found    = 1'b1;
         best_o.slot     = my_slot;
         best_o.deadline = deadline_ff;
      end
   end

   assign live        = live_ff;
   assign deadline    = deadline_ff;
   assign handle      = handle_ff;
   assign notify_flag = notify_ff;

endmodule

// ===== hw/rtl/deadline_timer_queue.sv =====
// ============================================================================
// deadline_timer_queue: fixed-capacity timer store with earliest-deadline scan
// Sequencer and a row of slot cells; the running minimum walks the row.
// ============================================================================
// Usage: raise start with req_* for one cycle while busy is low. Add, cancel
// and query answer with one rsp_strobe pulse carrying rsp_last; expire gives
// one pulse per due timer in deadline order (lower slot first on ties), up
// to 16, the final one with rsp_last, or a single empty pulse if nothing is due.
// Add and cancel answer in the cycle right after acceptance. Query and each
// expired timer take one scan of the whole row, then form the result in
// S_EMIT: the running minimum steps through one cell per cycle. The scan
// also counts the due timers, so the last pulse is known when it is shown.
// busy stays high until the last result of the transaction has been shown.
// The receiver cannot stall: every result is on the rsp_ ports for exactly
// one cycle. Reset clears all live flags, leaving the queue empty; the
// stored payload needs no clearing.
// ============================================================================
module deadline_timer_queue (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic [1:0]                      req_command,
   input  logic [47:0]                     req_now_ms,
   input  logic [31:0]                     req_timeout_ms,
   input  logic [15:0]                     req_conn_handle,
   input  logic                            req_notify,
   input  logic [3:0]                      req_slot_id,
   output logic                            rsp_strobe,
   output logic [1:0]                      rsp_status,
   output logic [3:0]                      rsp_new_slot,
   output logic [30:0]                     rsp_remaining_ms,
   output logic                            rsp_expired_valid,
   output logic [15:0]                     rsp_expired_handle,
   output logic                            rsp_expired_notify,
   output logic                            rsp_last
);
   import dtq_pkg::*;

   localparam int CntBits = $clog2(Capacity + 1);
   localparam int EmitBits = $clog2(MaxResults + 1);

   state_type state_ff, state_in;
   cmd_type   cmd_ff, cmd_in;
   logic [TimeBits-1:0]   now_ff;
   logic [CntBits-1:0]    pos_ff, pos_in;
   logic [CntBits-1:0]    due_ff, due_in;
   logic [EmitBits-1:0]   nemit_ff, nemit_in;
   best_type              acc_ff, acc_in;

   best_type              chain [Capacity];
   logic [Capacity-1:0]   live_v;
   logic [TimeBits-1:0]   dl_v [Capacity];
   logic [HandleBits-1:0] hdl_v [Capacity];
   logic [Capacity-1:0]   ntf_v;
   cell_ctl_type          ctl;
   logic [TimeBits-1:0]   wr_dl;
   logic [TimeBits:0]     dl_sum;

   logic                  accept;
   logic [SlotBits-1:0]   free_slot;
   logic                  any_free;
   logic                  slot_ok;

   // Response register
   logic                  rsp_v_ff, rsp_v_in;
   logic [1:0]            st_ff, st_in;
   logic [3:0]            ns_ff, ns_in;
   logic [RemainBits-1:0] rem_ff, rem_in;
   logic                  ev_ff, ev_in;
   logic [15:0]           eh_ff, eh_in;
   logic                  en_ff, en_in;
   logic                  last_ff, last_in;

   assign accept = start && !busy;

   // Lowest free slot (priority over live bits)
   always_comb begin
      free_slot = '0;
      any_free  = 1'b0;
      for (int i = Capacity - 1; i >= 0; i--) begin
         if (!live_v[i]) begin
            free_slot = SlotBits'(i);
            any_free  = 1'b1;
         end
      end
   end

   assign slot_ok = (32'(req_slot_id) < 32'(Capacity)) &&
                    live_v[SlotBits'(req_slot_id)];

   // Saturating deadline
   assign dl_sum = {1'b0, req_now_ms} + {{(TimeBits-32+1){1'b0}}, req_timeout_ms};
   assign wr_dl  = dl_sum[TimeBits] ? TimeMax : dl_sum[TimeBits-1:0];

   // Cell row; the scan feeds the register back through one cell a cycle
   genvar g;
   generate
      for (g = 0; g < Capacity; g++) begin : g_cell
         best_type b_in;
         assign b_in = (pos_ff[SlotBits-1:0] == SlotBits'(g)) ? acc_ff : '0;
         dtq_cell u_cell (
            .clock       (clock),
            .reset       (reset),
            .my_slot     (SlotBits'(g)),
            .ctl         (ctl),
            .wr_deadline (wr_dl),
            .wr_handle   (HandleBits'(req_conn_handle)),
            .wr_notify   (req_notify),
            .best_i      (b_in),
            .best_o      (chain[g]),
            .live        (live_v[g]),
            .deadline    (dl_v[g]),
            .handle      (hdl_v[g]),
            .notify_flag (ntf_v[g])
         );
      end
   endgenerate

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept && (req_command == CMD_QUERY || req_command == CMD_EXPIRE))
               state_in = S_SCAN;
         end
         S_SCAN: begin
            if (32'(pos_ff) == Capacity - 1) state_in = S_EMIT;
         end
         S_EMIT: begin
            if (cmd_ff == CMD_EXPIRE && acc_ff.found && acc_ff.deadline <= now_ff &&
                due_ff > CntBits'(1) && 32'(nemit_ff) + 1 < MaxResults)
               state_in = S_SCAN;
            else
               state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Datapath and outputs
   always_comb begin
      cmd_in   = cmd_ff;
      pos_in   = pos_ff;
      due_in   = due_ff;
      nemit_in = nemit_ff;
      acc_in   = acc_ff;
      ctl      = '0;
      rsp_v_in = 1'b0;
      st_in    = ST_OK;
      ns_in    = '0;
      rem_in   = '0;
      ev_in    = 1'b0;
      eh_in    = '0;
      en_in    = 1'b0;
      last_in  = 1'b1;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cmd_in   = cmd_type'(req_command);
               pos_in   = '0;
               due_in   = '0;
               nemit_in = '0;
               acc_in   = '0;
               case (cmd_type'(req_command))
                  CMD_ADD: begin
                     rsp_v_in = 1'b1;
                     if (any_free) begin
                        ctl.write = 1'b1;
                        ctl.slot  = free_slot;
                        ns_in     = 4'(free_slot);
                     end else begin
                        st_in = ST_FULL;
                     end
                  end
                  CMD_CANCEL: begin
                     rsp_v_in = 1'b1;
                     if (slot_ok) begin
                        ctl.clear = 1'b1;
                        ctl.slot  = SlotBits'(req_slot_id);
                     end else begin
                        st_in = ST_BADID;
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_SCAN: begin
            acc_in = chain[pos_ff[SlotBits-1:0]];
            pos_in = pos_ff + 1'b1;
            // Count live timers already due
            if (live_v[pos_ff[SlotBits-1:0]] && dl_v[pos_ff[SlotBits-1:0]] <= now_ff)
               due_in = due_ff + 1'b1;
         end
         S_EMIT: begin
            rsp_v_in = 1'b1;
            pos_in   = '0;
            due_in   = '0;
            acc_in   = '0;
            if (cmd_ff == CMD_QUERY) begin
               if (!acc_ff.found) st_in = ST_EMPTY;
               else if (acc_ff.deadline > now_ff) begin
                  if (acc_ff.deadline - now_ff > {{(TimeBits-RemainBits){1'b0}}, RemainMax})
                     rem_in = RemainMax;
                  else
                     rem_in = RemainBits'(acc_ff.deadline - now_ff);
               end
            end else if (acc_ff.found && acc_ff.deadline <= now_ff) begin
               ctl.clear = 1'b1;
               ctl.slot  = acc_ff.slot;
               ev_in     = 1'b1;
               eh_in     = 16'(hdl_v[acc_ff.slot]);
               en_in     = ntf_v[acc_ff.slot];
               nemit_in  = nemit_ff + 1'b1;
               last_in   = (due_ff == CntBits'(1)) || !(32'(nemit_ff) + 1 < MaxResults);
            end else if (nemit_ff != '0) begin
               // Previous pulse already carried last
               rsp_v_in = 1'b0;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rsp_v_ff <= 1'b0;
         pos_ff   <= '0;
         nemit_ff <= '0;
      end else begin
         state_ff <= state_in;
         rsp_v_ff <= rsp_v_in;
         pos_ff   <= pos_in;
         nemit_ff <= nemit_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff  <= cmd_in;
      acc_ff  <= acc_in;
      due_ff  <= due_in;
      st_ff   <= st_in;
      ns_ff   <= ns_in;
      rem_ff  <= rem_in;
      ev_ff   <= ev_in;
      eh_ff   <= eh_in;
      en_ff   <= en_in;
      last_ff <= last_in;
      if (accept) now_ff <= req_now_ms;
   end

   assign busy               = (state_ff != S_IDLE) || rsp_v_ff;
   assign rsp_strobe         = rsp_v_ff;
   assign rsp_status         = st_ff;
   assign rsp_new_slot       = ns_ff;
   assign rsp_remaining_ms   = rem_ff;
   assign rsp_expired_valid  = ev_ff;
   assign rsp_expired_handle = eh_ff;
   assign rsp_expired_notify = en_ff;
   assign rsp_last           = last_ff;

   // Protocol and state checks
   a_strobe_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> busy);
   a_accept_idle: assert property (@(posedge clock) disable iff (reset)
      accept |-> state_ff == S_IDLE);
   a_state_legal: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_IDLE || state_ff == S_SCAN || state_ff == S_EMIT);
   a_scan_pos: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_SCAN |-> 32'(pos_ff) < Capacity);
   a_expired_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_expired_valid |-> rsp_status == ST_OK);

endmodule
